/* rtl/complex_bin_unit_norm_macros.svh */
// Assertion macros used by the unit-norm RTL.
`ifndef COMPLEX_BIN_UNIT_NORM_MACROS_SVH
`define COMPLEX_BIN_UNIT_NORM_MACROS_SVH

`ifndef SYNTHESIS
`define CBUN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CBUN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CBUN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define CBUN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/cbun_pkg.sv */
// Types and constants of the complex bin unit-norm block.
package cbun_pkg;

	localparam int NUM_BINS_DEF = 512;
	localparam int RAMP_TOP = 16777;
	localparam int RAMP_SPAN = 15099;
	localparam logic [15:0] ALPHA_RESET = 16'd64881;
	localparam logic [23:0] POS_MAX = 24'h7FFFFF;
	localparam logic [23:0] NEG_MIN = 24'h800000;

	typedef struct packed {
		logic [8:0] bin_index;
		logic signed [23:0] real_part;
		logic signed [23:0] imag_part;
	} bin_word_t;

	typedef struct packed {
		logic signed [23:0] norm_real;
		logic signed [23:0] norm_imag;
		logic clipped;
	} res_word_t;

	typedef struct packed {
		logic signed [23:0] re;
		logic signed [23:0] im;
	} sample_t;

endpackage

/* rtl/complex_bin_unit_norm.sv */
// Top level of the complex bin unit-norm pipeline.
//
//   channel | signals                          | carries
//   --------+----------------------------------+--------------------------------
//   bin     | bin_valid, bin_ready, bin_word   | bin index, real and imag part
//   res     | res_valid, res_ready, res_word   | normalized parts, clip flag
//   cfg     | cfg_we, cfg_data                 | smoothing factor, no wait
//
// One word enters per cycle unless res stalls or the ramp fill is running.
// The path holds two square root pipelines and a divider, one bit per stage.
// After reset the mean memory is filled with the ramp, one bin after another, bin_ready low.
// A stall on res freezes every stage at once; the mean update is forwarded between
// neighboring words of the same bin, so back-to-back words of one bin are fine.
`include "complex_bin_unit_norm_macros.svh"

module complex_bin_unit_norm import cbun_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      bin_valid,
	output logic      bin_ready,
	input  bin_word_t bin_word,
	output logic      res_valid,
	input  logic      res_ready,
	output res_word_t res_word,
	input  logic      cfg_we,
	input  logic [15:0] cfg_data
);

	localparam int IW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int MG_N = 32;
	localparam int RT_N = 24;
	localparam int DV_N = 24;
	localparam int MSH = 9 + $clog2(NUM_BINS);
	localparam longint MMUL = ((64'd1 << MSH) + NUM_BINS - 1) / NUM_BINS;
	localparam logic [13:0] RD = 14'(NUM_BINS - 1);
	localparam logic [14:0] RQ = 15'(RAMP_SPAN / (NUM_BINS - 1));
	localparam logic [13:0] RR = 14'(RAMP_SPAN % (NUM_BINS - 1));
	localparam logic [13:0] RH = 14'((NUM_BINS - 1) / 2);

	logic adv;
	logic take;

	// configuration
	logic [15:0] alpha_q;

	// ramp fill
	logic init_busy_q;
	logic [IW-1:0] init_cnt_q;
	logic [14:0] ramp_step_q;
	logic [13:0] ramp_rem_q;
	logic [13:0] ramp_sum;
	logic ramp_carry;
	logic [31:0] ramp_val;

	// mean memory
	logic [31:0] mem_q [NUM_BINS];

	// front stages
	logic [31:0] mq;
	logic [31:0] mprod;
	logic [31:0] bin_ext;
	logic [31:0] mrem;
	logic vld_s1, vld_s2, vld_s3;
	logic [IW-1:0] idx_s1, idx_s2, idx_s3;
	sample_t smp_s1, smp_s2, smp_s3;
	logic [23:0] are_s1, aim_s1;
	logic [46:0] sqr_re_s2, sqr_im_s2;
	logic [47:0] energy_s3;

	// magnitude square root
	logic mg_vld_s [1:MG_N];
	logic [63:0] mg_v_s [1:MG_N];
	logic [35:0] mg_rem_s [1:MG_N];
	logic [31:0] mg_root_s [1:MG_N];
	logic [IW-1:0] mg_idx_s [1:MG_N];
	sample_t mg_smp_s [1:MG_N];

	// mean update
	logic [16:0] wgt;
	logic [48:0] pre_c;
	logic vld_s4, vld_s5, vld_s6;
	logic [IW-1:0] idx_s4, idx_s5, idx_s6;
	sample_t smp_s4, smp_s5, smp_s6;
	logic [48:0] pre_s4, pre_s5;
	logic [31:0] rd_s5;
	logic [31:0] mean_s6;
	logic [31:0] old_c;
	logic [49:0] sum_c;
	logic [31:0] mean_c;

	// mean square root
	logic rt_vld_s [1:RT_N];
	logic [31:0] rt_mean_s [1:RT_N];
	logic [27:0] rt_rem_s [1:RT_N];
	logic [23:0] rt_root_s [1:RT_N];
	sample_t rt_smp_s [1:RT_N];

	// divider
	logic [23:0] root_c;
	logic vld_s7;
	logic [23:0] root_s7;
	logic neg_s7 [0:1];
	logic ovf_s7 [0:1];
	logic [23:0] a_s7 [0:1];
	logic [24:0] rem_s7 [0:1];
	logic dv_vld_s [1:DV_N];
	logic [23:0] dv_root_s [1:DV_N];
	logic [1:0] dv_neg_s [1:DV_N];
	logic [1:0] dv_ovf_s [1:DV_N];
	logic [23:0] dv_a_s [1:DV_N][0:1];
	logic [24:0] dv_rem_s [1:DV_N][0:1];
	logic [23:0] dv_q_s [1:DV_N][0:1];

	// output register
	logic res_vld_q;
	res_word_t res_word_q;
	logic [23:0] out_val [0:1];
	logic out_clip [0:1];

	assign adv = !res_vld_q || res_ready;
	assign bin_ready = adv && !init_busy_q;
	assign take = bin_valid && bin_ready;
	assign res_valid = res_vld_q;
	assign res_word = res_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (cfg_we) begin
			alpha_q <= cfg_data;
		end
	end

	assign ramp_sum = ramp_rem_q + RR;
	assign ramp_carry = ramp_sum >= RD;
	assign ramp_val = 32'(15'(RAMP_TOP) - ramp_step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_busy_q <= 1'b1;
			init_cnt_q <= '0;
			ramp_step_q <= '0;
			ramp_rem_q <= RH;
		end else if (init_busy_q) begin
			init_cnt_q <= init_cnt_q + 1'b1;
			ramp_step_q <= ramp_step_q + RQ + 15'(ramp_carry);
			ramp_rem_q <= ramp_carry ? ramp_sum - RD : ramp_sum;
			if (init_cnt_q == IW'(NUM_BINS - 1)) begin
				init_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (init_busy_q) begin
			mem_q[init_cnt_q] <= ramp_val;
		end else if (adv && vld_s5) begin
			mem_q[idx_s5] <= mean_c;
		end
		if (adv) begin
			rd_s5 <= mem_q[idx_s4];
		end
	end

	// Bin index modulo NUM_BINS by reciprocal multiply with one correction.
	always_comb begin
		bin_ext = 32'(bin_word.bin_index);
		mq = 32'((64'(bin_word.bin_index) * 64'(MMUL)) >> MSH);
		mprod = 32'(mq * 32'(NUM_BINS));
		if (mprod > bin_ext) begin
			mrem = bin_ext + 32'(NUM_BINS) - mprod;
		end else begin
			mrem = bin_ext - mprod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= mg_vld_s[MG_N];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= rt_vld_s[RT_N];
			res_vld_q <= dv_vld_s[DV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= mrem[IW-1:0];
			smp_s1 <= '{re: bin_word.real_part, im: bin_word.imag_part};
			are_s1 <= bin_word.real_part[23] ? 24'(-bin_word.real_part) : bin_word.real_part;
			aim_s1 <= bin_word.imag_part[23] ? 24'(-bin_word.imag_part) : bin_word.imag_part;
			idx_s2 <= idx_s1;
			smp_s2 <= smp_s1;
			sqr_re_s2 <= 47'(are_s1) * 47'(are_s1);
			sqr_im_s2 <= 47'(aim_s1) * 47'(aim_s1);
			idx_s3 <= idx_s2;
			smp_s3 <= smp_s2;
			energy_s3 <= 48'(sqr_re_s2) + 48'(sqr_im_s2);
		end
	end

	for (genvar k = 1; k <= MG_N; k++) begin : g_mg
		logic [63:0] v_p;
		logic [35:0] rem_p;
		logic [31:0] root_p;
		logic [IW-1:0] idx_p;
		sample_t smp_p;
		logic vld_p;
		logic [35:0] rem_t;
		logic [35:0] trial;
		logic hit;
		if (k == 1) begin : g_src
			assign v_p = {energy_s3, 16'd0};
			assign rem_p = '0;
			assign root_p = '0;
			assign idx_p = idx_s3;
			assign smp_p = smp_s3;
			assign vld_p = vld_s3;
		end else begin : g_src
			assign v_p = mg_v_s[k-1];
			assign rem_p = mg_rem_s[k-1];
			assign root_p = mg_root_s[k-1];
			assign idx_p = mg_idx_s[k-1];
			assign smp_p = mg_smp_s[k-1];
			assign vld_p = mg_vld_s[k-1];
		end
		assign rem_t = {rem_p[33:0], v_p[65-2*k -: 2]};
		assign trial = {2'b00, root_p, 2'b01};
		assign hit = rem_t >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mg_vld_s[k] <= 1'b0;
			end else if (adv) begin
				mg_vld_s[k] <= vld_p;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				mg_v_s[k] <= v_p;
				mg_rem_s[k] <= hit ? rem_t - trial : rem_t;
				mg_root_s[k] <= {root_p[30:0], hit};
				mg_idx_s[k] <= idx_p;
				mg_smp_s[k] <= smp_p;
			end
		end
	end

	assign wgt = 17'h10000 - {1'b0, alpha_q};
	assign pre_c = 49'(mg_root_s[MG_N]) * 49'(wgt) + 49'd32768;

	// The previous word of the same bin has not reached memory yet: take it from stage 6.
	assign old_c = (vld_s6 && idx_s6 == idx_s5) ? mean_s6 : rd_s5;
	assign sum_c = 50'(pre_s5) + 50'(old_c) * 50'(alpha_q);
	assign mean_c = sum_c[47:16];

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s4 <= mg_idx_s[MG_N];
			smp_s4 <= mg_smp_s[MG_N];
			pre_s4 <= pre_c;
			idx_s5 <= idx_s4;
			smp_s5 <= smp_s4;
			pre_s5 <= pre_s4;
			idx_s6 <= idx_s5;
			smp_s6 <= smp_s5;
			mean_s6 <= mean_c;
		end
	end

	for (genvar k = 1; k <= RT_N; k++) begin : g_rt
		logic [31:0] mean_p;
		logic [27:0] rem_p;
		logic [23:0] root_p;
		sample_t smp_p;
		logic vld_p;
		logic [47:0] v_p;
		logic [27:0] rem_t;
		logic [27:0] trial;
		logic hit;
		if (k == 1) begin : g_src
			assign mean_p = mean_s6;
			assign rem_p = '0;
			assign root_p = '0;
			assign smp_p = smp_s6;
			assign vld_p = vld_s6;
		end else begin : g_src
			assign mean_p = rt_mean_s[k-1];
			assign rem_p = rt_rem_s[k-1];
			assign root_p = rt_root_s[k-1];
			assign smp_p = rt_smp_s[k-1];
			assign vld_p = rt_vld_s[k-1];
		end
		assign v_p = {mean_p, 16'd0};
		assign rem_t = {rem_p[25:0], v_p[49-2*k -: 2]};
		assign trial = {2'b00, root_p, 2'b01};
		assign hit = rem_t >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k] <= 1'b0;
			end else if (adv) begin
				rt_vld_s[k] <= vld_p;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rt_mean_s[k] <= mean_p;
				rt_rem_s[k] <= hit ? rem_t - trial : rem_t;
				rt_root_s[k] <= {root_p[22:0], hit};
				rt_smp_s[k] <= smp_p;
			end
		end
	end

	assign root_c = (rt_root_s[RT_N] == 24'd0) ? 24'd1 : rt_root_s[RT_N];

	for (genvar p = 0; p < 2; p++) begin : g_pre
		logic [23:0] part;
		logic [23:0] a_c;
		if (p == 0) begin : g_sel
			assign part = rt_smp_s[RT_N].re;
		end else begin : g_sel
			assign part = rt_smp_s[RT_N].im;
		end
		assign a_c = part[23] ? 24'(-part) : part;
		always_ff @(posedge clk) begin
			if (adv) begin
				neg_s7[p] <= part[23];
				a_s7[p] <= a_c;
				ovf_s7[p] <= {4'd0, a_c} >= {root_c, 4'd0};
				rem_s7[p] <= {5'd0, a_c[23:4]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			root_s7 <= root_c;
		end
	end

	for (genvar j = 1; j <= DV_N; j++) begin : g_dv
		localparam int DB = DV_N - j;
		logic [23:0] root_p;
		logic [1:0] neg_p;
		logic [1:0] ovf_p;
		logic vld_p;
		if (j == 1) begin : g_src
			assign root_p = root_s7;
			assign neg_p = {neg_s7[1], neg_s7[0]};
			assign ovf_p = {ovf_s7[1], ovf_s7[0]};
			assign vld_p = vld_s7;
		end else begin : g_src
			assign root_p = dv_root_s[j-1];
			assign neg_p = dv_neg_s[j-1];
			assign ovf_p = dv_ovf_s[j-1];
			assign vld_p = dv_vld_s[j-1];
		end
		for (genvar p = 0; p < 2; p++) begin : g_part
			logic [23:0] a_p;
			logic [24:0] rem_p;
			logic [23:0] q_p;
			logic dbit;
			logic [24:0] rem_t;
			logic hit;
			if (j == 1) begin : g_src
				assign a_p = a_s7[p];
				assign rem_p = rem_s7[p];
				assign q_p = '0;
			end else begin : g_src
				assign a_p = dv_a_s[j-1][p];
				assign rem_p = dv_rem_s[j-1][p];
				assign q_p = dv_q_s[j-1][p];
			end
			if (DB >= 20) begin : g_bit
				assign dbit = a_p[DB-20];
			end else begin : g_bit
				assign dbit = 1'b0;
			end
			assign rem_t = {rem_p[23:0], dbit};
			assign hit = rem_t >= {1'b0, root_p};
			always_ff @(posedge clk) begin
				if (adv) begin
					dv_a_s[j][p] <= a_p;
					dv_rem_s[j][p] <= hit ? rem_t - {1'b0, root_p} : rem_t;
					dv_q_s[j][p] <= {q_p[22:0], hit};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[j] <= vld_p;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_root_s[j] <= root_p;
				dv_neg_s[j] <= neg_p;
				dv_ovf_s[j] <= ovf_p;
			end
		end
	end

	for (genvar p = 0; p < 2; p++) begin : g_sat
		logic [23:0] q;
		logic ovf;
		assign q = dv_q_s[DV_N][p];
		assign ovf = dv_ovf_s[DV_N][p];
		always_comb begin
			if (!dv_neg_s[DV_N][p]) begin
				out_clip[p] = ovf || q[23];
				out_val[p] = out_clip[p] ? POS_MAX : q;
			end else begin
				out_clip[p] = ovf || (q[23] && (q[22:0] != 23'd0));
				out_val[p] = out_clip[p] ? NEG_MIN : 24'(-q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_word_q.norm_real <= out_val[0];
			res_word_q.norm_imag <= out_val[1];
			res_word_q.clipped <= out_clip[0] || out_clip[1];
		end
	end

	`CBUN_ASSERT_NEXT(a_fill_stays_done, clk, arst_n, !init_busy_q, !init_busy_q, "ramp fill restarted")
	`CBUN_ASSERT_NOW(a_no_take_in_fill, clk, arst_n, init_busy_q, !bin_ready, "word taken during ramp fill")
	`CBUN_ASSERT_NOW(a_root_nonzero, clk, arst_n, vld_s7, root_s7 != 24'd0, "zero root reached the divider")
	`CBUN_ASSERT_NEXT(a_stall_freezes, clk, arst_n, !adv, vld_s5 == $past(vld_s5) && vld_s6 == $past(vld_s6), "mean stages moved during a stall")

endmodule
